[src/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Field widths, opcode names, sequencer states and the cell update command.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_FIELD_W = 32;  // key field on the request bus
  localparam int VALUE_W     = 31;  // stored value width
  localparam int CAP_W       = 5;   // capacity register width
  localparam int S_TDATA_W   = 64;  // key + value, padded to bytes
  localparam int M_TDATA_W   = 32;  // read_value, padded to bytes

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } state_t;

  // what the cells do on the update cycle
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_HIT,    // promote the matching cell
    UPD_EVICT,  // overwrite the least recent cell
    UPD_FILL    // write the first empty cell
  } upd_kind_t;

  typedef struct packed {
    upd_kind_t kind;
    logic      wr_value;  // hit on a put: take the new value
  } upd_ctl_t;

endpackage

[src/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell: one cache entry
// Holds key, value, valid and recency rank; compares against the request key
// and applies the broadcast promote / write command.
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int KW = 32,
  parameter int RW = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           look,
  input  logic [KW-1:0]                  req_key,
  input  lkvc_pkg::upd_ctl_t             ctl,
  input  logic                           fill_sel,
  input  logic [RW-1:0]                  prom_rank,
  input  logic [lkvc_pkg::VALUE_W-1:0]   wr_value,
  output logic                           match,
  output logic [RW-1:0]                  match_rank,
  output logic [lkvc_pkg::VALUE_W-1:0]   match_value,
  output logic                           valid
);

  logic [KW-1:0]                key;
  logic [lkvc_pkg::VALUE_W-1:0] value;
  logic [RW-1:0]                rank;
  logic                         eq;
  logic                         target;

  assign eq = valid && (key == req_key);

  always_comb begin
    case (ctl.kind)
      lkvc_pkg::UPD_HIT:   target = match;
      lkvc_pkg::UPD_EVICT: target = valid && (rank == prom_rank);
      lkvc_pkg::UPD_FILL:  target = fill_sel;
      default:             target = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
      match <= 1'b0;
    end else begin
      if (look) begin
        match <= eq;
      end
      if (ctl.kind != lkvc_pkg::UPD_NONE) begin
        if (target) begin
          rank  <= '0;
          valid <= 1'b1;
        end else if (valid && (rank < prom_rank)) begin
          rank <= rank + 1'b1;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (look) begin
      match_rank  <= eq ? rank : '0;
      match_value <= eq ? value : '0;
    end
    if (target && (ctl.kind != lkvc_pkg::UPD_HIT)) begin
      key <= req_key;
    end
    if (target && ((ctl.kind != lkvc_pkg::UPD_HIT) || ctl.wr_value)) begin
      value <= wr_value;
    end
  end

endmodule

[src/lkvc_merge.sv]
// ----------------------------------------------------------------------------
// lkvc_merge: hit collection
// ORs the masked per-cell match results; at most one cell matches.
// ----------------------------------------------------------------------------
module lkvc_merge #(
  parameter int N  = 16,
  parameter int RW = 4
) (
  input  logic [N-1:0]                          match,
  input  logic [N-1:0][RW-1:0]                  rank_in,
  input  logic [N-1:0][lkvc_pkg::VALUE_W-1:0]   value_in,
  output logic                                  hit,
  output logic [RW-1:0]                         hit_rank,
  output logic [lkvc_pkg::VALUE_W-1:0]          hit_value
);

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      hit_rank  = hit_rank | rank_in[i];
      hit_value = hit_value | value_in[i];
    end
    hit = |match;
  end

endmodule

[src/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Row of entry cells with broadcast compare and rank update.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = opcode (0 get, 1 put), tdata = key
//   and value. m_axis returns one result per request: tuser = hit, tdata =
//   read_value (stored value on a get hit, else 0). cfg_* writes the
//   capacity register (1..16 used; 0 acts as 1, above ENTRIES saturates);
//   write it only while no request is in flight.
// Timing:
//   A request runs in steps: accept, key compare in every cell (result
//   registered in the cell), then hit merge plus rank/slot update, which
//   also loads the output register. Result shows on m_axis the cycle after
//   the update. A new request is taken only once the current one has left
//   the update step, so requests do not overlap.
// Reset:
//   All entries invalid, occupancy 0, capacity 16. No clearing pass; keys
//   and values are only read once their entry is valid.
// Stall:
//   A finished result waits in the output register. The next request is
//   still accepted and compared; its update step holds until the output
//   register is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // request: tdata [31:0] key, [62:32] value, [63] zero; tuser [0] opcode
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lkvc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tuser,
  // result: tdata [30:0] read_value, [31] zero; tuser [0] hit
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lkvc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser,
  // capacity write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]        cfg_data
);

  // compared key width: the key field caps it
  localparam int KW = (KEY_BITS < lkvc_pkg::KEY_FIELD_W) ? KEY_BITS : lkvc_pkg::KEY_FIELD_W;
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W;
  localparam int VW = lkvc_pkg::VALUE_W;

  lkvc_pkg::state_t state, state_next;

  logic                        req_put;
  logic [KW-1:0]               req_key;
  logic [VW-1:0]               req_value;
  logic [lkvc_pkg::CAP_W-1:0]  capacity;
  logic [OW-1:0]               occ;
  logic                        out_valid;
  logic                        out_hit;
  logic [VW-1:0]               out_value;

  logic                        look;
  logic                        load;
  logic [CW-1:0]               cap_w;
  logic [CW-1:0]               eff_cap;
  logic                        full;
  lkvc_pkg::upd_kind_t         kind;
  lkvc_pkg::upd_ctl_t          ctl;
  logic [RW-1:0]               prom_rank;

  logic [ENTRIES-1:0]          match_vec;
  logic [ENTRIES-1:0]          valid_vec;
  logic [ENTRIES-1:0]          fill_sel;
  logic [ENTRIES-1:0][RW-1:0]  rank_vec;
  logic [ENTRIES-1:0][VW-1:0]  value_vec;
  logic                        hit;
  logic [RW-1:0]               hit_rank;
  logic [VW-1:0]               hit_value;

  assign s_axis_tready = (state == lkvc_pkg::ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_hit;
  assign m_axis_tdata  = {1'b0, out_value};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    look       = 1'b0;
    load       = 1'b0;
    case (state)
      lkvc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = lkvc_pkg::ST_LOOK;
      end
      lkvc_pkg::ST_LOOK: begin
        look       = 1'b1;
        state_next = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (!out_valid || m_axis_tready) begin
          load       = 1'b1;
          state_next = lkvc_pkg::ST_IDLE;
        end
      end
      default: state_next = lkvc_pkg::ST_IDLE;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_put   <= (s_axis_tuser == lkvc_pkg::OP_PUT);
      req_key   <= s_axis_tdata[KW-1:0];
      req_value <= s_axis_tdata[lkvc_pkg::KEY_FIELD_W +: VW];
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // zero acts as one, above ENTRIES saturates
  assign cap_w   = CW'(capacity);
  assign eff_cap = (cap_w == '0) ? CW'(1) :
                   ((cap_w > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_w);
  assign full    = (CW'(occ) >= eff_cap);

  // update command; valid cells always sit at indexes 0..occ-1, so a fill
  // goes to index occ and an eviction reuses the victim in place
  always_comb begin
    if (hit) begin
      kind      = lkvc_pkg::UPD_HIT;
      prom_rank = hit_rank;
    end else if (req_put && full) begin
      kind      = lkvc_pkg::UPD_EVICT;
      prom_rank = RW'(occ - 1'b1);
    end else if (req_put) begin
      kind      = lkvc_pkg::UPD_FILL;
      prom_rank = RW'(occ);
    end else begin
      kind      = lkvc_pkg::UPD_NONE;
      prom_rank = '0;
    end
    ctl.kind     = load ? kind : lkvc_pkg::UPD_NONE;
    ctl.wr_value = req_put;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctl.kind == lkvc_pkg::UPD_FILL) begin
      occ <= occ + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_hit   <= hit;
      out_value <= (hit && !req_put) ? hit_value : '0;
    end
  end

  // entry row
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign fill_sel[i] = (occ == OW'(i));

    lkvc_cell #(
      .KW (KW),
      .RW (RW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .look        (look),
      .req_key     (req_key),
      .ctl         (ctl),
      .fill_sel    (fill_sel[i]),
      .prom_rank   (prom_rank),
      .wr_value    (req_value),
      .match       (match_vec[i]),
      .match_rank  (rank_vec[i]),
      .match_value (value_vec[i]),
      .valid       (valid_vec[i])
    );
  end

  lkvc_merge #(
    .N  (ENTRIES),
    .RW (RW)
  ) u_merge (
    .match     (match_vec),
    .rank_in   (rank_vec),
    .value_in  (value_vec),
    .hit       (hit),
    .hit_rank  (hit_rank),
    .hit_value (hit_value)
  );

  // checks
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    (state == lkvc_pkg::ST_UPDATE) |-> $onehot0(match_vec))
    else $error("more than one entry matched");

  a_occ_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(occ))
    else $error("occupancy disagrees with valid entries");

  a_occ_max: assert property (@(posedge clk) disable iff (rst)
    int'(occ) <= ENTRIES)
    else $error("occupancy above entry count");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss result carries data");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == lkvc_pkg::ST_LOOK))
    else $error("accepted request not compared");

endmodule
